[rtl/core/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared widths, edge codes and the beat types that move down the clipper.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int TBits     = FracBits + 1;
  localparam int NumLanes  = 4;

  // Edge classification
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ENTER = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  localparam logic [TBits-1:0] T_ONE = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic [1:0]           kind;
    logic                 sat;
    logic [CoordBits-1:0] den;
    logic [CoordBits-1:0] rem;
    logic [FracBits-1:0]  quo;
  } lane_t;

  typedef struct packed {
    lane_t [NumLanes-1:0]        lane;
    logic                        reject;
    logic signed [CoordBits-1:0] x1;
    logic signed [CoordBits-1:0] y1;
    logic signed [CoordBits:0]   dx;
    logic signed [CoordBits:0]   dy;
  } seg_t;

endpackage

[rtl/core/line_segment_clipper.sv]
// ----------------------------------------------------------------------------
// line_segment_clipper
// Liang-Barsky clipping of one segment per beat against a configured window.
// ----------------------------------------------------------------------------
// Takes one segment per cycle while in_tready is high and returns one
// result beat per segment, in order. The path is one edge setup stage, a
// chain of FracBits divider cells (16-bit fraction) that each resolve a bit
// of every lane's edge parameter t, then a t-select stage, a multiply stage
// and a round stage. Every stage holds its beat only while the stage after it
// is full and stalled, so bubbles collapse and the input keeps flowing while
// a result waits at the output, until every stage is full. Write the window
// only while idle; writes to indexes beyond 3 are dropped. visible travels on
// out_tuser; invisible segments return zero coordinates.
module line_segment_clipper (
  input  logic        clk,
  input  logic        rst_n,
  // config write: index 0 x_min, 1 y_min, 2 x_max, 3 y_max
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // segment in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x, start_y, end_x, end_y
  // result out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [0:0]  out_tuser   // visible
);

  localparam int CB = lsc_pkg::CoordBits;
  localparam int FB = lsc_pkg::FracBits;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  logic signed [CB-1:0] x_min_r, y_min_r, x_max_r, y_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= CB'(0);
      y_min_r <= CB'(0);
      x_max_r <= CB'(639);
      y_max_r <= CB'(479);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN: x_min_r <= cfg_data;
        REG_Y_MIN: y_min_r <= cfg_data;
        REG_X_MAX: x_max_r <= cfg_data;
        REG_Y_MAX: y_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // beats between stages: slot 0 from edge setup, slot k from cell k-1
  logic          vld [FB+1];
  logic          rdy [FB+1];
  lsc_pkg::seg_t seg [FB+1];

  lsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_x_min (x_min_r),
    .win_y_min (y_min_r),
    .win_x_max (x_max_r),
    .win_y_max (y_max_r),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .sx        (in_tdata[15:0]),
    .sy        (in_tdata[31:16]),
    .ex        (in_tdata[47:32]),
    .ey        (in_tdata[63:48]),
    .out_vld   (vld[0]),
    .out_rdy   (rdy[0]),
    .out_seg   (seg[0])
  );

  // divider chain: each cell appends one quotient bit
  for (genvar k = 0; k < FB; k++) begin : g_cell
    lsc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[k]),
      .in_rdy  (rdy[k]),
      .in_seg  (seg[k]),
      .out_vld (vld[k+1]),
      .out_rdy (rdy[k+1]),
      .out_seg (seg[k+1])
    );
  end

  logic                 vis;
  logic signed [CB-1:0] csx, csy, cex, cey;

  lsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (vld[FB]),
    .in_rdy      (rdy[FB]),
    .in_seg      (seg[FB]),
    .out_vld     (out_tvalid),
    .out_rdy     (out_tready),
    .out_visible (vis),
    .out_sx      (csx),
    .out_sy      (csy),
    .out_ex      (cex),
    .out_ey      (cey)
  );

  assign out_tdata = {cey, cex, csy, csx};
  assign out_tuser = vis;

endmodule

[rtl/core/lsc_front.sv]
// ----------------------------------------------------------------------------
// lsc_front
// Edge setup: form p and q per window edge and seed the divider lanes.
// ----------------------------------------------------------------------------
module lsc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [lsc_pkg::CoordBits-1:0] win_x_min,
  input  logic signed [lsc_pkg::CoordBits-1:0] win_y_min,
  input  logic signed [lsc_pkg::CoordBits-1:0] win_x_max,
  input  logic signed [lsc_pkg::CoordBits-1:0] win_y_max,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  logic signed [lsc_pkg::CoordBits-1:0] sx,
  input  logic signed [lsc_pkg::CoordBits-1:0] sy,
  input  logic signed [lsc_pkg::CoordBits-1:0] ex,
  input  logic signed [lsc_pkg::CoordBits-1:0] ey,
  output logic                                 out_vld,
  input  logic                                 out_rdy,
  output lsc_pkg::seg_t                        out_seg
);

  localparam int CB = lsc_pkg::CoordBits;

  logic                 vld_r;
  lsc_pkg::seg_t        seg_r;
  lsc_pkg::seg_t        seg_nxt;
  logic signed [CB:0]   p [lsc_pkg::NumLanes];
  logic signed [CB:0]   q [lsc_pkg::NumLanes];
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;

  assign dx = $signed({ex[CB-1], ex}) - $signed({sx[CB-1], sx});
  assign dy = $signed({ey[CB-1], ey}) - $signed({sy[CB-1], sy});

  always_comb begin
    p[0] = -dx;
    q[0] = $signed({sx[CB-1], sx}) - $signed({win_x_min[CB-1], win_x_min});
    p[1] = dx;
    q[1] = $signed({win_x_max[CB-1], win_x_max}) - $signed({sx[CB-1], sx});
    p[2] = -dy;
    q[2] = $signed({sy[CB-1], sy}) - $signed({win_y_min[CB-1], win_y_min});
    p[3] = dy;
    q[3] = $signed({win_y_max[CB-1], win_y_max}) - $signed({sy[CB-1], sy});
  end

  always_comb begin
    logic [CB:0] pa;
    logic [CB:0] qa;
    seg_nxt.reject = 1'b0;
    seg_nxt.x1     = sx;
    seg_nxt.y1     = sy;
    seg_nxt.dx     = dx;
    seg_nxt.dy     = dy;
    for (int i = 0; i < lsc_pkg::NumLanes; i++) begin
      pa = p[i][CB] ? -p[i] : p[i];
      qa = q[i][CB] ? -q[i] : q[i];
      seg_nxt.lane[i].kind = lsc_pkg::KIND_NONE;
      seg_nxt.lane[i].den  = pa[CB-1:0];
      seg_nxt.lane[i].rem  = qa[CB-1:0];
      seg_nxt.lane[i].quo  = '0;
      seg_nxt.lane[i].sat  = (qa[CB-1:0] >= pa[CB-1:0]);
      if (p[i] == '0) begin
        if (q[i][CB]) seg_nxt.reject = 1'b1;
      end else if (p[i][CB]) begin
        if (q[i][CB]) seg_nxt.lane[i].kind = lsc_pkg::KIND_ENTER;
      end else begin
        if (q[i][CB]) seg_nxt.reject = 1'b1;
        else seg_nxt.lane[i].kind = lsc_pkg::KIND_EXIT;
      end
      // a saturated lane divides nothing
      if (seg_nxt.lane[i].sat) seg_nxt.lane[i].rem = '0;
    end
  end

  assign in_rdy = ~vld_r | out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_seg = seg_r;

endmodule

[rtl/core/lsc_div_cell.sv]
// ----------------------------------------------------------------------------
// lsc_div_cell
// One restoring-division step: one quotient bit for each of the four lanes.
// ----------------------------------------------------------------------------
module lsc_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  lsc_pkg::seg_t in_seg,
  output logic          out_vld,
  input  logic          out_rdy,
  output lsc_pkg::seg_t out_seg
);

  localparam int CB = lsc_pkg::CoordBits;
  localparam int FB = lsc_pkg::FracBits;

  logic          vld_r;
  lsc_pkg::seg_t seg_r;
  lsc_pkg::seg_t seg_nxt;

  always_comb begin
    logic [CB:0] sh;
    logic [CB:0] diff;
    logic        ge;
    seg_nxt = in_seg;
    for (int i = 0; i < lsc_pkg::NumLanes; i++) begin
      sh   = {in_seg.lane[i].rem, 1'b0};
      diff = sh - {1'b0, in_seg.lane[i].den};
      ge   = (sh >= {1'b0, in_seg.lane[i].den});
      seg_nxt.lane[i].rem = ge ? diff[CB-1:0] : sh[CB-1:0];
      seg_nxt.lane[i].quo = {in_seg.lane[i].quo[FB-2:0], ge};
    end
  end

  assign in_rdy = ~vld_r | out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_seg = seg_r;

endmodule

[rtl/core/lsc_back.sv]
// ----------------------------------------------------------------------------
// lsc_back
// Pick t_enter / t_exit, scale the deltas, then round the endpoints.
// ----------------------------------------------------------------------------
module lsc_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  lsc_pkg::seg_t                        in_seg,
  output logic                                 out_vld,
  input  logic                                 out_rdy,
  output logic                                 out_visible,
  output logic signed [lsc_pkg::CoordBits-1:0] out_sx,
  output logic signed [lsc_pkg::CoordBits-1:0] out_sy,
  output logic signed [lsc_pkg::CoordBits-1:0] out_ex,
  output logic signed [lsc_pkg::CoordBits-1:0] out_ey
);

  localparam int CB = lsc_pkg::CoordBits;
  localparam int FB = lsc_pkg::FracBits;
  localparam int TB = lsc_pkg::TBits;
  localparam int NW = FB + CB + 3;

  // stage A: t select
  logic                 a_vld_r;
  logic                 a_rdy;
  logic                 a_vis_r;
  logic [TB-1:0]        a_ten_r;
  logic [TB-1:0]        a_tex_r;
  logic signed [CB-1:0] a_x1_r;
  logic signed [CB-1:0] a_y1_r;
  logic signed [CB:0]   a_dx_r;
  logic signed [CB:0]   a_dy_r;
  logic [TB-1:0]        ten_nxt;
  logic [TB-1:0]        tex_nxt;

  always_comb begin
    logic [TB-1:0] t;
    ten_nxt = '0;
    tex_nxt = lsc_pkg::T_ONE;
    for (int i = 0; i < lsc_pkg::NumLanes; i++) begin
      t = in_seg.lane[i].sat ? lsc_pkg::T_ONE : {1'b0, in_seg.lane[i].quo};
      if (in_seg.lane[i].kind == lsc_pkg::KIND_ENTER && t > ten_nxt) ten_nxt = t;
      if (in_seg.lane[i].kind == lsc_pkg::KIND_EXIT && t < tex_nxt) tex_nxt = t;
    end
  end

  assign in_rdy = ~a_vld_r | a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_rdy) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      a_vis_r <= ~in_seg.reject & (ten_nxt < tex_nxt);
      a_ten_r <= ten_nxt;
      a_tex_r <= tex_nxt;
      a_x1_r  <= in_seg.x1;
      a_y1_r  <= in_seg.y1;
      a_dx_r  <= in_seg.dx;
      a_dy_r  <= in_seg.dy;
    end
  end

  // stage B: t * delta
  logic                 b_vld_r;
  logic                 b_rdy;
  logic                 b_vis_r;
  logic signed [CB-1:0] b_x1_r;
  logic signed [CB-1:0] b_y1_r;
  logic signed [NW-1:0] b_psx_r;
  logic signed [NW-1:0] b_psy_r;
  logic signed [NW-1:0] b_pex_r;
  logic signed [NW-1:0] b_pey_r;

  assign a_rdy = ~b_vld_r | b_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      b_vis_r <= a_vis_r;
      b_x1_r  <= a_x1_r;
      b_y1_r  <= a_y1_r;
      b_psx_r <= $signed({1'b0, a_ten_r}) * a_dx_r;
      b_psy_r <= $signed({1'b0, a_ten_r}) * a_dy_r;
      b_pex_r <= $signed({1'b0, a_tex_r}) * a_dx_r;
      b_pey_r <= $signed({1'b0, a_tex_r}) * a_dy_r;
    end
  end

  // stage C: add start, truncate toward zero
  function automatic logic [CB-1:0] rnd_coord(input logic [CB-1:0] c,
                                              input logic [NW-1:0] prod);
    logic [NW-1:0] num;
    logic          adj;
    num = {{3{c[CB-1]}}, c, {FB{1'b0}}} + prod;
    adj = num[NW-1] & (|num[FB-1:0]);
    return num[FB+CB-1:FB] + {{(CB-1){1'b0}}, adj};
  endfunction

  logic c_vld_r;

  assign b_rdy = ~c_vld_r | out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (b_rdy) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      out_visible <= b_vis_r;
      out_sx <= b_vis_r ? rnd_coord(b_x1_r, b_psx_r) : '0;
      out_sy <= b_vis_r ? rnd_coord(b_y1_r, b_psy_r) : '0;
      out_ex <= b_vis_r ? rnd_coord(b_x1_r, b_pex_r) : '0;
      out_ey <= b_vis_r ? rnd_coord(b_y1_r, b_pey_r) : '0;
    end
  end

  assign out_vld = c_vld_r;

endmodule

[bench/line_segment_clipper_tb.sv]
// ----------------------------------------------------------------------------
// line_segment_clipper_tb
// Self-checking bench for the Liang-Barsky segment clipper.
// ----------------------------------------------------------------------------
// Segments stream in from a queue. A clocked driver and a clocked monitor
// apply random idle and stall cycles, with one long output hold-off so the
// pipeline fills and backpressures. Every accepted segment is clipped by a
// behavioral model in the bench. The expected beat is queued and compared
// field by field with each result beat. The window is rewritten between
// phases, always while the pipeline is empty.
module line_segment_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency    = lsc_pkg::FracBits + 4;
  localparam int CycleLimit = 400000;
  localparam longint TOne   = 64'sd1 << lsc_pkg::FracBits;

  // register indexes
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef struct packed {
    logic signed [15:0] x1, y1, x2, y2;
  } segment_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] sx, sy, ex, ey;
  } clipped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;

  line_segment_clipper dut (.*);

  always #1 clk = ~clk;

  // window as the bench sees it
  logic signed [15:0] win_x_min = 16'sd0, win_y_min = 16'sd0;
  logic signed [15:0] win_x_max = 16'sd639, win_y_max = 16'sd479;

  segment_t segs_pending[$];
  clipped_t clips_expected[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit calm = 1'b0;            // no idling or stalling while set
  int hold_off = 0;           // long output hold-off, counted down by the monitor

  // point on the segment at parameter t, truncated toward zero
  function automatic logic [15:0] lerp(longint c, longint d, longint t);
    longint num;
    num = c * TOne + t * d;
    return 16'(num / TOne);
  endfunction

  function automatic clipped_t clip_segment(segment_t s);
    longint x1, y1, dx, dy, t, t_enter, t_exit;
    longint p[4], q[4];
    bit reject;
    clipped_t r;
    x1 = s.x1;
    y1 = s.y1;
    dx = longint'(s.x2) - x1;
    dy = longint'(s.y2) - y1;
    p[0] = -dx; q[0] = x1 - win_x_min;
    p[1] = dx;  q[1] = win_x_max - x1;
    p[2] = -dy; q[2] = y1 - win_y_min;
    p[3] = dy;  q[3] = win_y_max - y1;
    t_enter = 0;
    t_exit = TOne;
    reject = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) reject = 1'b1;
      end else if (p[i] < 0) begin
        // entering edge: only moves t_enter when start is outside it
        if (q[i] < 0) begin
          t = (-q[i] * TOne) / (-p[i]);
          if (t > TOne) t = TOne;
          if (t > t_enter) t_enter = t;
        end
      end else if (q[i] < 0) begin
        reject = 1'b1;
      end else begin
        t = (q[i] * TOne) / p[i];
        if (t > TOne) t = TOne;
        if (t < t_exit) t_exit = t;
      end
    end
    r = '0;
    if (!reject && t_enter < t_exit) begin
      r.visible = 1'b1;
      r.sx = lerp(x1, dx, t_enter);
      r.sy = lerp(y1, dy, t_enter);
      r.ex = lerp(x1, dx, t_exit);
      r.ey = lerp(y1, dy, t_exit);
    end
    return r;
  endfunction

  // Driver: advance to the next segment on each accepted beat, idle at random.
  // tdata packs start_x lowest, then start_y, end_x, end_y.
  always @(posedge clk) begin
    segment_t s;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        clips_expected.push_back(clip_segment(segment_t'({in_tdata[15:0], in_tdata[31:16],
                                                          in_tdata[47:32], in_tdata[63:48]})));
      end
      if (!in_tvalid || in_tready) begin
        if (segs_pending.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
          s = segs_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {s.y2, s.x2, s.y1, s.x1};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk) begin
    clipped_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[63:48], out_tdata[47:32], out_tdata[31:16],
               out_tdata[15:0]};
        // tdata packs clip_start_x lowest
        got.sx = out_tdata[15:0];
        got.sy = out_tdata[31:16];
        got.ex = out_tdata[47:32];
        got.ey = out_tdata[63:48];
        if (clips_expected.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          error_count++;
        end else begin
          want = clips_expected.pop_front();
          if (got.visible !== want.visible)
            $display("%0t: visible expected %0d actual %0d", $time, want.visible, got.visible);
          if (got.sx !== want.sx)
            $display("%0t: clip_start_x expected %0d actual %0d", $time, want.sx, got.sx);
          if (got.sy !== want.sy)
            $display("%0t: clip_start_y expected %0d actual %0d", $time, want.sy, got.sy);
          if (got.ex !== want.ex)
            $display("%0t: clip_end_x expected %0d actual %0d", $time, want.ex, got.ex);
          if (got.ey !== want.ey)
            $display("%0t: clip_end_y expected %0d actual %0d", $time, want.ey, got.ey);
          if (got !== want) error_count++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= 17;
      end
    end
  end

  // Present one register beat; the caller drops cfg_valid after the last one.
  task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_MIN: win_x_min = val;
      REG_Y_MIN: win_y_min = val;
      REG_X_MAX: win_x_max = val;
      default:   win_y_max = val;
    endcase
  endtask

  task automatic set_window(logic signed [15:0] x0, y0, x1, y1);
    write_reg(REG_X_MIN, x0);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_X_MAX, x1);
    write_reg(REG_Y_MAX, y1);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the pipeline to drain before touching the window.
  task automatic drain();
    while (segs_pending.size() > 0 || in_tvalid || clips_expected.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord(logic signed [15:0] lo, logic signed [15:0] hi);
    int r;
    r = $urandom_range(9);
    if (r < 2) return 16'($urandom);
    if (r == 2) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return 16'(int'(lo) - 40 + int'($urandom_range(32'(int'(hi) - int'(lo) + 80))));
  endfunction

  task automatic random_segments(int n);
    segment_t s;
    repeat (n) begin
      s.x1 = pick_coord(win_x_min, win_x_max);
      s.y1 = pick_coord(win_y_min, win_y_max);
      case ($urandom_range(7))
        0: begin s.x2 = s.x1; s.y2 = s.y1; end
        1: begin s.x2 = s.x1; s.y2 = pick_coord(win_y_min, win_y_max); end
        2: begin s.x2 = pick_coord(win_x_min, win_x_max); s.y2 = s.y1; end
        default: begin
          s.x2 = pick_coord(win_x_min, win_x_max);
          s.y2 = pick_coord(win_y_min, win_y_max);
        end
      endcase
      segs_pending.push_back(s);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default window
    segs_pending.push_back('{16'sd10, 16'sd10, 16'sd100, 16'sd200});     // fully inside
    segs_pending.push_back('{-16'sd100, 16'sd240, 16'sd800, 16'sd240});  // crosses x_min and x_max
    segs_pending.push_back('{16'sd320, -16'sd50, 16'sd320, 16'sd600});   // crosses y_min and y_max
    segs_pending.push_back('{-16'sd5, 16'sd100, -16'sd5, 16'sd200});     // parallel, outside
    segs_pending.push_back('{16'sd5, 16'sd100, 16'sd5, 16'sd200});       // parallel, inside
    segs_pending.push_back('{16'sd700, 16'sd10, 16'sd800, 16'sd20});     // leaving edge behind start
    segs_pending.push_back('{16'sd50, 16'sd50, 16'sd50, 16'sd50});       // point inside
    segs_pending.push_back('{16'sd50, 16'sd500, 16'sd50, 16'sd500});     // point outside
    segs_pending.push_back('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}); // full span
    segs_pending.push_back('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}); // reversed
    segs_pending.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    segs_pending.push_back('{-16'sd1, -16'sd1, 16'sd0, 16'sd0});         // touches corner
    segs_pending.push_back('{16'sd639, 16'sd479, 16'sd1000, 16'sd1000}); // leaves at corner
    segs_pending.push_back('{16'sd600, 16'sd0, 16'sd700, -16'sd10});
    drain();

    // inverted window rejects everything
    set_window(16'sd100, 16'sd100, -16'sd100, -16'sd100);
    segs_pending.push_back('{-16'sd200, -16'sd200, 16'sd200, 16'sd200});
    segs_pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    random_segments(30);
    drain();

    // extreme window, calm and under long output hold-off
    set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    calm = 1'b1;
    random_segments(100);
    drain();
    calm = 1'b0;
    hold_off = 300;
    random_segments(150);
    drain();

    set_window(-16'sd50, 16'sd20, 16'sd50, 16'sd25);
    random_segments(200);
    drain();

    set_window(-16'sd1000, -16'sd3000, 16'sd2000, 16'sd500);
    random_segments(200);
    drain();

    if (error_count == 0) begin
      $display("line_segment_clipper verification clean");
    end else begin
      $display("line_segment_clipper verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("line_segment_clipper verification failed");
      $finish;
    end
  end

endmodule

[line_segment_clipper.f]
rtl/core/lsc_pkg.sv
rtl/core/lsc_front.sv
rtl/core/lsc_div_cell.sv
rtl/core/lsc_back.sv
rtl/core/line_segment_clipper.sv
bench/line_segment_clipper_tb.sv
